>>> rtl/nfa_pkg.sv
// package for the subset construction block: types, constants, controller codes
// no dependencies
`timescale 1ns / 1ps
package nfa_pkg;
   localparam int NfaStates    = 8;
   localparam int MaxSymbols   = 4;
   localparam int MaxDfaStates = 16;
   localparam int RowLen       = MaxSymbols + 1;
   localparam int StoreDepth   = NfaStates * RowLen;
   localparam int StoreAw      = $clog2(StoreDepth);
   localparam int StW          = $clog2(NfaStates);
   localparam int DfaW         = $clog2(MaxDfaStates);

   localparam logic [1:0] CsrStateCount  = 2'd0;
   localparam logic [1:0] CsrStartState  = 2'd1;
   localparam logic [1:0] CsrFinalMask   = 2'd2;
   localparam logic [1:0] CsrSymbolCount = 2'd3;

   typedef struct packed {
      logic       action;
      logic [2:0] nfa_state;
      logic [1:0] symbol;
      logic       is_epsilon;
      logic [7:0] target_mask;
   } req_type;

   typedef struct packed {
      logic [3:0] source_dfa;
      logic [1:0] out_symbol;
      logic [3:0] target_dfa;
      logic       source_final;
      logic       overflow;
      logic       last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_START, ST_CLOSE, ST_SRC, ST_MOVE, ST_MOVEW, ST_SEARCH,
      ST_EMIT, ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load_row;
      logic init_run;
      logic close_step;
      logic src_read;
      logic move_init;
      logic move_step;
      logic search_init;
      logic search_step;
      logic append;
      logic emit;
      logic emit_ovf;
      logic emit_last;
      logic next_sym;
      logic next_src;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic close_done;
      logic move_done;
      logic found;
      logic search_end;
      logic full;
      logic last_sym;
      logic last_src;
   } sts_type;
endpackage

>>> rtl/nfa_ram.sv
// generic simple dual port ram (one write port, one read port) with registered read
// no dependencies
`timescale 1ns / 1ps
module nfa_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> rtl/nfa_datapath.sv
// datapath: csr registers, transition store, subset store, closure and search
// depends on nfa_pkg and nfa_ram
`timescale 1ns / 1ps
module nfa_datapath import nfa_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            csr_valid,
   input  logic [1:0]      csr_index,
   input  logic [7:0]      csr_data,
   input  req_type         req_data,
   input  cmd_type         cmd,
   output sts_type         sts,
   output rsp_type         rsp_data
);
   logic [3:0] state_count_ff;
   logic [2:0] start_state_ff;
   logic [7:0] final_mask_ff;
   logic [2:0] symbol_count_ff;

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         state_count_ff  <= 4'd8;
         start_state_ff  <= 3'd0;
         final_mask_ff   <= 8'd0;
         symbol_count_ff <= 3'd4;
      end else if (csr_valid) begin
         case (csr_index)
            CsrStateCount:  state_count_ff  <= csr_data[3:0];
            CsrStartState:  start_state_ff  <= csr_data[2:0];
            CsrFinalMask:   final_mask_ff   <= csr_data;
            CsrSymbolCount: symbol_count_ff <= csr_data[2:0];
            default: ;
         endcase
      end
   end

   // saturated counts
   logic [3:0] nstates;
   logic [2:0] nsyms;
   logic [7:0] active;
   always_comb begin
      nstates = state_count_ff;
      if (nstates == 4'd0) nstates = 4'd1;
      if (nstates > 4'(NfaStates)) nstates = 4'(NfaStates);
      nsyms = symbol_count_ff;
      if (nsyms == 3'd0) nsyms = 3'd1;
      if (nsyms > 3'(MaxSymbols)) nsyms = 3'(MaxSymbols);
      active = 8'((9'd1 << nstates) - 9'd1);
   end

   // epsilon rows in flops; symbol rows in flops too (32 x 8
   // bits, each read by a mux of the move walk)
   logic [7:0] eps_ff [NfaStates];
   logic [7:0] sym_ff [NfaStates][MaxSymbols];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NfaStates; i++) begin
            eps_ff[i] <= 8'd0;
            for (int j = 0; j < MaxSymbols; j++) sym_ff[i][j] <= 8'd0;
         end
      end else if (cmd.load_row) begin
         if (req_data.is_epsilon) eps_ff[req_data.nfa_state] <= req_data.target_mask;
         else sym_ff[req_data.nfa_state][req_data.symbol] <= req_data.target_mask;
      end
   end

   // working set, closure by one parallel sweep per cycle
   logic [7:0] work_ff, work_in, sweep;
   logic [2:0] mstate_ff;
   logic [1:0] sym_ff_idx;
   logic [DfaW-1:0] cur_ff;
   logic [DfaW:0] k_ff;
   logic [4:0] count_ff;
   logic [7:0] src_set;
   always_comb begin
      sweep = work_ff;
      for (int i = 0; i < NfaStates; i++)
         if (work_ff[i]) sweep = sweep | (eps_ff[i] & active);
   end
   assign sts.close_done = (sweep == work_ff);

   always_comb begin
      work_in = work_ff;
      if (cmd.init_run)
         work_in = (4'(start_state_ff) < nstates) ? (8'd1 << start_state_ff) : 8'd0;
      else if (cmd.close_step) work_in = sweep;
      else if (cmd.move_init) work_in = 8'd0;
      else if (cmd.move_step && src_set[mstate_ff])
         work_in = work_ff | (sym_ff[mstate_ff][sym_ff_idx] & active);
   end
   always_ff @(posedge clock) work_ff <= work_in;

   always_ff @(posedge clock) begin
      if (cmd.move_init) mstate_ff <= 3'd0;
      else if (cmd.move_step) mstate_ff <= mstate_ff + 3'd1;
   end
   assign sts.move_done = cmd.move_step && ({1'b0, mstate_ff} == nstates - 4'd1);

   // subset store ram
   logic            ram_we;
   logic [DfaW-1:0] ram_wa, ram_ra;
   logic [8:0]      ram_rd;
   assign ram_we = cmd.append;
   assign ram_wa = count_ff[DfaW-1:0];
   assign ram_ra = cmd.src_read ? cur_ff : k_ff[DfaW-1:0];
   nfa_ram #(.Width(9), .Depth(MaxDfaStates)) u_subsets (
      .clock(clock), .wr_en(ram_we), .wr_addr(ram_wa),
      .wr_data({|(work_ff & final_mask_ff), work_ff}),
      .rd_addr(ram_ra), .rd_data(ram_rd));

   // source set and finality latched after read
   logic [7:0] src_ff;
   logic       src_fin_ff, src_pend_ff;
   always_ff @(posedge clock) begin
      if (reset) src_pend_ff <= 1'b0;
      else src_pend_ff <= cmd.src_read;
      if (src_pend_ff) begin
         src_ff     <= ram_rd[7:0];
         src_fin_ff <= ram_rd[8];
      end
   end
   assign src_set = src_ff;

   // search walk: one registered read per step, index one bit wider than the store
   logic [DfaW-1:0] hit_ff;
   logic            rd_pend_ff;
   always_ff @(posedge clock) begin
      if (reset) rd_pend_ff <= 1'b0;
      else rd_pend_ff <= cmd.search_step;
      if (cmd.search_init) k_ff <= '0;
      else if (cmd.search_step) k_ff <= k_ff + 1'b1;
   end
   logic [DfaW-1:0] k_prev;
   assign k_prev = k_ff[DfaW-1:0] - 1'b1;
   assign sts.found = rd_pend_ff && (ram_rd[7:0] == work_ff);
   assign sts.search_end = (k_ff >= count_ff);
   assign sts.full = (count_ff >= 5'(MaxDfaStates));
   always_ff @(posedge clock) begin
      if (sts.found) hit_ff <= k_prev;
      else if (cmd.append) hit_ff <= count_ff[DfaW-1:0];
   end

   // run counters
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 5'd0;
         cur_ff <= '0;
         sym_ff_idx <= 2'd0;
      end else begin
         if (cmd.init_run) begin
            count_ff <= 5'd0;
            cur_ff <= '0;
            sym_ff_idx <= 2'd0;
         end
         if (cmd.append) count_ff <= count_ff + 5'd1;
         if (cmd.next_sym) sym_ff_idx <= sym_ff_idx + 2'd1;
         if (cmd.next_src) begin
            sym_ff_idx <= 2'd0;
            cur_ff <= cur_ff + 1'b1;
         end
      end
   end
   assign sts.last_sym = ({1'b0, sym_ff_idx} == nsyms - 3'd1);
   assign sts.last_src = ({1'b0, cur_ff} + 5'd1 >= count_ff);

   // result
   always_comb begin
      rsp_data.source_dfa   = 4'(cur_ff);
      rsp_data.out_symbol   = sym_ff_idx;
      rsp_data.target_dfa   = cmd.emit_ovf ? 4'd0 : 4'(hit_ff);
      rsp_data.source_final = src_fin_ff;
      rsp_data.overflow     = cmd.emit_ovf;
      rsp_data.last         = cmd.emit_last;
   end
endmodule

>>> rtl/nfa_ctrl.sv
// controller state machine for the subset construction run
// depends on nfa_pkg
`timescale 1ns / 1ps
module nfa_ctrl import nfa_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_start,
   input  logic    req_action,
   input  sts_type sts,
   output cmd_type cmd,
   output logic    busy,
   output logic    rsp_valid
);
   state_type state_ff, state_in;
   logic      first_ff, first_in, ovf_ff, ovf_in;
   logic      emit_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         first_ff <= 1'b0;
         ovf_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
         ovf_ff   <= ovf_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      ovf_in   = ovf_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_start && req_action) begin
               state_in = ST_START;
            end
         end
         ST_START: begin
            state_in = ST_CLOSE;
            first_in = 1'b1;
         end
         ST_CLOSE: begin
            if (sts.close_done) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SRC:   state_in = ST_MOVEW;
         ST_MOVEW: state_in = ST_MOVE;
         ST_MOVE: begin
            if (sts.move_done) begin
               state_in = ST_CLOSE;
            end
         end
         ST_SEARCH: begin
            if (first_ff) begin
               first_in = 1'b0;
               state_in = ST_SRC;
            end else if (sts.found || sts.search_end) begin
               ovf_in   = !sts.found && sts.full;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (ovf_ff || (sts.last_sym && sts.last_src)) begin
               state_in = ST_DONE;
               ovf_in   = 1'b0;
            end else begin
               state_in = sts.last_sym ? ST_SRC : ST_MOVEW;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd = '0;
      emit_now = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load_row = req_start && !req_action;
            cmd.init_run = req_start && req_action;
         end
         ST_START: cmd.move_init = 1'b0;
         ST_CLOSE: begin
            cmd.close_step  = !sts.close_done;
            cmd.search_init = sts.close_done;
         end
         ST_SRC: cmd.src_read = 1'b1;
         ST_MOVEW: cmd.move_init = 1'b1;
         ST_MOVE: cmd.move_step = 1'b1;
         ST_SEARCH: begin
            if (first_ff) begin
               cmd.append = 1'b1;
            end else if (!(sts.found || sts.search_end)) begin
               cmd.search_step = 1'b1;
            end else if (!sts.found && !sts.full) begin
               cmd.append = 1'b1;
            end
         end
         ST_EMIT: begin
            emit_now      = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_ovf  = ovf_ff;
            cmd.emit_last = ovf_ff || (sts.last_sym && sts.last_src);
            cmd.next_sym  = !sts.last_sym;
            cmd.next_src  = sts.last_sym && !cmd.emit_last;
         end
         default: ;
      endcase
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = emit_now;
endmodule

>>> rtl/nfa_to_dfa_subset_construction.sv
// subset construction top: a load row leaves busy low
// a run holds busy from its accept edge through the done state after its last result; per
// table entry: the move walk (after a source read on a new source), the epsilon closure
// sweeps, the search walk over the known dfa states, and the emit
// results strobe for one cycle each and the receiver cannot stall them; one run at a time
// reset (synchronous, active high) clears the transition store and resets the csr registers and control state
`timescale 1ns / 1ps
module nfa_to_dfa_subset_construction import nfa_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  req_type    req_data,
   output logic       rsp_valid,
   output rsp_type    rsp_data,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data
);
   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   nfa_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_start(start), .req_action(req_data.action),
      .sts(sts), .cmd(cmd), .busy(busy), .rsp_valid(rsp_valid));

   nfa_datapath u_dp (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_index(csr_index),
      .csr_data(csr_data), .req_data(req_data), .cmd(cmd), .sts(sts),
      .rsp_data(rsp_data));
endmodule

>>> tb/tb_nfa_to_dfa_subset_construction.sv
// testbench for the subset construction block: directed table, then random loads and runs
// depends on nfa_pkg and nfa_to_dfa_subset_construction
`timescale 1ns / 1ps
module tb_nfa_to_dfa_subset_construction;
   import nfa_pkg::*;

   logic       clock;
   logic       reset;
   logic       start;
   logic       busy;
   req_type    req_data;
   logic       rsp_valid;
   rsp_type    rsp_data;
   logic       csr_valid;
   logic       csr_ready;
   logic [1:0] csr_index;
   logic [7:0] csr_data;

   nfa_to_dfa_subset_construction dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   // predictor state
   logic [7:0] row_mem [NfaStates][RowLen];
   logic [3:0] cfg_states;
   logic [2:0] cfg_start;
   logic [7:0] cfg_final;
   logic [2:0] cfg_syms;

   rsp_type    table_q [$];
   int         errors;
   longint     cycles;

   // directed stimulus row: optional typed-in expectation of the first entry
   typedef struct {
      req_type item;
      bit      has_exp;
      rsp_type exp_first;
   } dir_row_type;

   always begin
      clock = 1'b0; #2;
      clock = 1'b1; #2;
   end

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 3000000) begin
         $display("tb_nfa_to_dfa_subset_construction failed");
         $finish;
      end
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   function automatic logic [7:0] close_set(logic [7:0] s, logic [7:0] act);
      logic [7:0] prev;
      s &= act;
      do begin
         prev = s;
         for (int i = 0; i < NfaStates; i++)
            if (s[i] && act[i]) s |= row_mem[i][MaxSymbols] & act;
      end while (s != prev);
      return s;
   endfunction

   // builds the dfa transition table and queues every entry
   task automatic build_table();
      int         nst, nsy, cnt, k, first;
      logic [7:0] act, ws, mv;
      logic [7:0] sets [MaxDfaStates];
      logic       fin  [MaxDfaStates];
      rsp_type    e;
      nst = (cfg_states < 1) ? 1 : (cfg_states > NfaStates ? NfaStates : cfg_states);
      nsy = (cfg_syms < 1) ? 1 : (cfg_syms > MaxSymbols ? MaxSymbols : cfg_syms);
      act = 8'((16'd1 << nst) - 1);
      ws = (cfg_start < nst) ? 8'(1 << cfg_start) : 8'd0;
      sets[0] = close_set(ws, act);
      fin[0] = |(sets[0] & cfg_final);
      cnt = 1;
      first = table_q.size();
      for (int c = 0; c < cnt; c++) begin
         for (int sy = 0; sy < nsy; sy++) begin
            mv = 0;
            for (int i = 0; i < nst; i++) if (sets[c][i]) mv |= row_mem[i][sy];
            ws = close_set(mv & act, act);
            for (k = 0; k < cnt; k++) if (sets[k] == ws) break;
            e.source_dfa = 4'(c);
            e.out_symbol = 2'(sy);
            e.source_final = fin[c];
            e.overflow = 1'b0;
            e.last = 1'b0;
            if (k == cnt) begin
               if (cnt >= MaxDfaStates) begin
                  e.target_dfa = 4'd0;
                  e.overflow = 1'b1;
                  e.last = 1'b1;
                  table_q.push_back(e);
                  return;
               end
               sets[k] = ws;
               fin[k] = |(ws & cfg_final);
               cnt++;
            end
            e.target_dfa = 4'(k);
            table_q.push_back(e);
         end
      end
      if (table_q.size() > first) table_q[table_q.size() - 1].last = 1'b1;
   endtask

   function automatic void apply_item(req_type it);
      int col;
      if (it.action) return;
      col = it.is_epsilon ? MaxSymbols : it.symbol;
      row_mem[it.nfa_state][col] = it.target_mask;
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid) begin
         if (table_q.size() == 0) begin
            report("entry with none expected");
         end else begin
            e = table_q.pop_front();
            if (rsp_data.source_dfa !== e.source_dfa)
               report($sformatf("source_dfa %0d exp %0d", rsp_data.source_dfa, e.source_dfa));
            if (rsp_data.out_symbol !== e.out_symbol)
               report($sformatf("out_symbol %0d exp %0d", rsp_data.out_symbol, e.out_symbol));
            if (rsp_data.target_dfa !== e.target_dfa)
               report($sformatf("target_dfa %0d exp %0d", rsp_data.target_dfa, e.target_dfa));
            if (rsp_data.source_final !== e.source_final)
               report("source_final");
            if (rsp_data.overflow !== e.overflow)
               report("overflow");
            if (rsp_data.last !== e.last)
               report("last");
         end
      end
   end

   task automatic wait_drained();
      while (table_q.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CsrStateCount:  cfg_states = val[3:0];
         CsrStartState:  cfg_start  = val[2:0];
         CsrFinalMask:   cfg_final  = val;
         CsrSymbolCount: cfg_syms   = val[2:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // one transfer; start stays high afterwards only when hold is set
   task automatic send(input req_type it, input bit hold);
      start <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      apply_item(it);
      if (it.action) build_table();
      @(negedge clock);
      if (!hold) begin
         start <= 1'b0;
         @(negedge clock);
      end
   endtask

   function automatic req_type load_row(int st, int sy, bit eps, int m);
      req_type r;
      r.action = 1'b0;
      r.nfa_state = 3'(st);
      r.symbol = 2'(sy);
      r.is_epsilon = eps;
      r.target_mask = 8'(m);
      return r;
   endfunction

   function automatic req_type rand_load();
      return load_row($urandom_range(7), $urandom_range(3), $urandom_range(4) == 0,
                      $urandom_range(255));
   endfunction

   function automatic req_type run_item();
      req_type r;
      r = rand_load();
      r.action = 1'b1;
      return r;
   endfunction

   initial begin
      dir_row_type dir [$];
      dir_row_type d;
      rsp_type     x;
      int          burst, n, nrun;
      errors = 0;
      cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CsrStateCount;
      csr_data = '0;
      foreach (row_mem[i, j]) row_mem[i][j] = '0;
      cfg_states = 4'd8;
      cfg_start = 3'd0;
      cfg_final = 8'd0;
      cfg_syms = 3'd4;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // run after reset: all moves empty, start {0} then dead state
      d.item = run_item();
      d.has_exp = 1;
      x.source_dfa = 0; x.out_symbol = 0; x.target_dfa = 1;
      x.source_final = 0; x.overflow = 0; x.last = 0;
      d.exp_first = x;
      dir.push_back(d);
      // chain 0-a->1-a->...-a->7, eps ring extremes
      d.has_exp = 0;
      for (int i = 0; i < 7; i++) begin
         d.item = load_row(i, 0, 0, 1 << (i + 1));
         dir.push_back(d);
      end
      d.item = load_row(7, 3, 0, 8'hff); dir.push_back(d);
      d.item = load_row(7, 0, 1, 8'h01); dir.push_back(d);
      d.item = load_row(3, 2, 1, 8'h80); dir.push_back(d);
      d.item = load_row(5, 1, 0, 8'h00); dir.push_back(d);
      d.item = run_item(); dir.push_back(d);
      d.item = load_row(2, 3, 0, 8'h55); dir.push_back(d);
      d.item = load_row(6, 1, 1, 8'haa); dir.push_back(d);
      d.item = run_item(); dir.push_back(d);

      foreach (dir[i]) begin
         send(dir[i].item, 0);
         if (dir[i].has_exp) begin
            x = table_q[0];
            if (x !== dir[i].exp_first) report("first entry after reset");
         end
      end
      wait_drained();

      // register extremes and out-of-range values, then random
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(CsrStateCount, 8'd1); write_reg(CsrSymbolCount, 8'd1);
                      write_reg(CsrStartState, 8'd0); write_reg(CsrFinalMask, 8'hff); end
            1: begin write_reg(CsrStateCount, 8'd15); write_reg(CsrSymbolCount, 8'd7);
                      write_reg(CsrStartState, 8'd7); write_reg(CsrFinalMask, 8'h80); end
            2: begin write_reg(CsrStateCount, 8'd0); write_reg(CsrSymbolCount, 8'd0);
                      write_reg(CsrStartState, 8'd3); write_reg(CsrFinalMask, 8'h00); end
            3: begin write_reg(CsrStateCount, 8'd4); write_reg(CsrStartState, 8'd6); end
            default: begin
               write_reg(CsrStateCount, 8'($urandom_range(1, 8)));
               write_reg(CsrSymbolCount, 8'($urandom_range(1, 4)));
               write_reg(CsrStartState, 8'($urandom_range(7)));
               write_reg(CsrFinalMask, 8'($urandom_range(255)));
            end
         endcase
         // bursts of mixed loads and runs, with random gaps
         n = 0;
         nrun = 0;
         while (n < 8 || nrun < 2) begin
            burst = $urandom_range(1, 8);
            for (int b = 0; b < burst; b++) begin
               if ($urandom_range(3) == 0) begin
                  send(run_item(), b < burst - 1);
                  nrun++;
               end else begin
                  send(rand_load(), b < burst - 1);
               end
               n++;
            end
            if ($urandom_range(2) == 0) repeat ($urandom_range(1, 6)) @(negedge clock);
         end
         // pause until the table has drained
         wait_drained();
      end
      // full sweep for overflow pressure: dense random rows, 8 states
      write_reg(CsrStateCount, 8'd8);
      write_reg(CsrSymbolCount, 8'd4);
      write_reg(CsrStartState, 8'd0);
      for (int i = 0; i < 8; i++)
         for (int j = 0; j < 4; j++) send(load_row(i, j, 0, $urandom_range(255)), 1);
      send(run_item(), 0);
      wait_drained();

      if (errors == 0) begin
         $display("tb_nfa_to_dfa_subset_construction passed");
      end else begin
         $display("tb_nfa_to_dfa_subset_construction failed");
      end
      $finish;
   end
endmodule
